### src/salc_pkg.sv
// Package for the set-associative LRU cache: geometry constants, address
// split and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package salc_pkg;

    localparam int WAYS       = 4;
    localparam int ADDR_W     = 11;
    localparam int TAG_W      = 5;
    localparam int SET_W      = 3;
    localparam int OFF_W      = 3;
    localparam int SETS       = 1 << SET_W;
    localparam int LINE_BYTES = 1 << OFF_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 32;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_IDX_W = SET_W + WAY_W + OFF_W;
    localparam int LINE_DEPTH = 1 << LINE_IDX_W;

    // stream payload widths
    localparam int IN_DATA_W  = ((ADDR_W + BYTE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BYTE_W + 2 * CNT_W + 7) / 8) * 8;

    typedef logic [WAYS-1:0][RANK_W-1:0] t_rank_row;
    typedef logic [WAYS-1:0][TAG_W-1:0]  t_tag_row;

    typedef struct packed {
        logic              load;
        logic              lookup;
        logic              hit_upd;
        logic              alloc;
        logic              fill;
        logic              emit;
        logic              clear;
        logic [OFF_W-1:0]  fill_off;
        logic [ADDR_W-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic hit_now;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

### src/salc_ctrl.sv
// Controller state machine for the LRU cache: clearing pass, lookup,
// allocate and refill sequencing. Uses salc_pkg.
`default_nettype none

module salc_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  salc_pkg::t_stat i_stat,
    output salc_pkg::t_cmd  o_cmd
);
    import salc_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_HIT    = 7'b0001000,
        S_ALLOC  = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_cnt, n_clr_cnt;
    logic [OFF_W-1:0]  r_fill_cnt, n_fill_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_cnt  <= '0;
            r_fill_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_fill_cnt <= n_fill_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_cnt  = r_clr_cnt;
        n_fill_cnt = r_fill_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.fill_off = r_fill_cnt;
        o_cmd.clr_addr = r_clr_cnt;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_clr_cnt   = r_clr_cnt + 1'b1;
                if (r_clr_cnt == {ADDR_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_stat.is_write || !i_stat.hit_now) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                o_cmd.hit_upd = 1'b1;
                n_state       = S_DONE;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_fill_cnt  = '0;
                n_state     = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_fill_cnt = r_fill_cnt + 1'b1;
                if (r_fill_cnt == OFF_W'(LINE_BYTES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // result waits here until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_LOOKUP))
        else $error("accepted item did not start a lookup");

    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_fill_cnt == OFF_W'(LINE_BYTES - 1)) |=> (r_state == S_DONE))
        else $error("line refill did not finish after the last byte");

endmodule

`default_nettype wire

### src/salc_dpath.sv
// Datapath for the LRU cache: tag/valid/rank arrays, line and backing
// memories, saturating counters and output register. Uses salc_pkg.
`default_nettype none

module salc_dpath (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  salc_pkg::t_cmd                    i_cmd,
    output salc_pkg::t_stat                   o_stat,
    input  wire                               i_in_mode,
    input  wire  [salc_pkg::IN_DATA_W-1:0]    i_in_data,
    input  wire                               i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_out_hit,
    output logic [salc_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import salc_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    // latched item
    logic              r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_wdata;

    logic [TAG_W-1:0] w_tag;
    logic [SET_W-1:0] w_set;
    logic [OFF_W-1:0] w_off;

    logic [WAYS-1:0] r_valid [SETS];
    t_tag_row        r_tag   [SETS];
    t_rank_row       r_rank  [SETS];

    logic [BYTE_W-1:0] r_back_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_line_mem [LINE_DEPTH];
    logic [BYTE_W-1:0] r_back_rd;
    logic [BYTE_W-1:0] r_line_rd;

    logic              w_hit_now;
    logic [WAY_W-1:0]  w_hit_way;
    logic [WAY_W-1:0]  w_vic_way;
    logic [WAY_W-1:0]  r_hit_way;
    logic [WAY_W-1:0]  r_vic_way;
    logic              r_hit;
    logic [BYTE_W-1:0] r_rd_byte;
    logic [OFF_W-1:0]  w_back_off;

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_miss;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [BYTE_W-1:0] r_out_rd;
    logic [CNT_W-1:0]  r_out_hits;
    logic [CNT_W-1:0]  r_out_miss;

    // way w becomes most recent; younger-or-equal ways age by one
    function automatic t_rank_row f_touch(t_rank_row rk, logic [WAY_W-1:0] w);
        t_rank_row         res;
        logic [RANK_W-1:0] r;
        r = rk[w];
        for (int v = 0; v < WAYS; v++) begin
            if (WAY_W'(v) != w && rk[v] <= r && rk[v] < RANK_MAX) begin
                res[v] = rk[v] + 1'b1;
            end else begin
                res[v] = rk[v];
            end
        end
        res[w] = '0;
        return res;
    endfunction

    assign w_tag = r_addr[ADDR_W-1:SET_W+OFF_W];
    assign w_set = r_addr[SET_W+OFF_W-1:OFF_W];
    assign w_off = r_addr[OFF_W-1:0];

    // first valid way with matching tag
    always_comb begin
        w_hit_now = 1'b0;
        w_hit_way = '0;
        for (int v = 0; v < WAYS; v++) begin
            if (!w_hit_now && r_valid[w_set][v] && r_tag[w_set][v] == w_tag) begin
                w_hit_now = 1'b1;
                w_hit_way = WAY_W'(v);
            end
        end
    end

    // first invalid way, else oldest rank with ties to the lower way
    always_comb begin
        logic             found;
        logic [WAY_W-1:0] best;
        found = 1'b0;
        best  = '0;
        w_vic_way = '0;
        for (int v = 0; v < WAYS; v++) begin
            if (!found && !r_valid[w_set][v]) begin
                found     = 1'b1;
                w_vic_way = WAY_W'(v);
            end
        end
        for (int v = 1; v < WAYS; v++) begin
            if (r_rank[w_set][v] > r_rank[w_set][best]) begin
                best = WAY_W'(v);
            end
        end
        if (!found) begin
            w_vic_way = best;
        end
    end

    assign w_back_off = i_cmd.alloc ? '0 : OFF_W'(i_cmd.fill_off + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_in_mode;
            r_addr  <= i_in_data[ADDR_W-1:0];
            r_wdata <= i_in_data[ADDR_W+BYTE_W-1:ADDR_W];
        end
        if (i_cmd.lookup) begin
            r_hit_way <= w_hit_way;
            r_hit     <= !r_mode && w_hit_now;
        end
        if (i_cmd.hit_upd) begin
            r_rd_byte <= r_line_rd;
        end
        if (i_cmd.alloc) begin
            r_vic_way <= w_vic_way;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
                r_tag[s]   <= '0;
                r_rank[s]  <= '0;
            end
        end else begin
            if (i_cmd.lookup && r_mode) begin
                // a write drops every way of the set with this tag, valid or not
                for (int v = 0; v < WAYS; v++) begin
                    if (r_tag[w_set][v] == w_tag) begin
                        r_valid[w_set][v] <= 1'b0;
                    end
                end
            end
            if (i_cmd.hit_upd) begin
                r_rank[w_set] <= f_touch(r_rank[w_set], r_hit_way);
            end
            if (i_cmd.alloc) begin
                r_valid[w_set][w_vic_way] <= 1'b1;
                r_tag[w_set][w_vic_way]   <= w_tag;
                r_rank[w_set]             <= f_touch(r_rank[w_set], w_vic_way);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_miss <= '0;
        end else begin
            if (i_cmd.lookup && !r_mode && !w_hit_now && r_miss != {CNT_W{1'b1}}) begin
                r_miss <= r_miss + 1'b1;
            end
            if (i_cmd.hit_upd && r_hits != {CNT_W{1'b1}}) begin
                r_hits <= r_hits + 1'b1;
            end
        end
    end

    // backing memory: one write port (clear or store), one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_back_mem[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.lookup && r_mode) begin
            r_back_mem[r_addr] <= r_wdata;
        end
        r_back_rd <= r_back_mem[{w_tag, w_set, w_back_off}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_line_mem[{w_set, r_vic_way, i_cmd.fill_off}] <= r_back_rd;
        end
        if (i_cmd.lookup) begin
            r_line_rd <= r_line_mem[{w_set, w_hit_way, w_off}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_hit  <= r_hit;
            r_out_rd   <= r_hit ? r_rd_byte : '0;
            r_out_hits <= r_hits;
            r_out_miss <= r_miss;
        end
    end

    assign o_stat.is_write = r_mode;
    assign o_stat.hit_now  = w_hit_now;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_data  = OUT_DATA_W'({r_out_miss, r_out_hits, r_out_rd});

    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |=> r_valid[w_set][r_vic_way])
        else $error("allocated way not marked valid");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> (r_out_hits != '0))
        else $error("hit reported with zero hit count");

endmodule

`default_nettype wire

### src/set_associative_lru_cache_unit.sv
// Top level of the set-associative LRU byte cache: joins controller and
// datapath to the stream ports. Uses salc_pkg, salc_ctrl, salc_dpath.
//
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: mode; tdata: address, write_data
// m_axis   out  m_axis_tvalid/m_axis_tready   tuser: hit; tdata: read_data, hit/miss totals
//
// Read hit: each item passes the accept, lookup, rank update and result steps.
// Read miss or write: accept, lookup, allocate, then the 8-byte refill through the
// single byte-wide read port of the backing memory, then the result.
// After reset a clearing pass zeroes all 2048 bytes of the backing memory with
// s_axis_tready low. A result waits in the output register while the next
// item is taken; the block holds in its last step until that register frees.
`default_nettype none

module set_associative_lru_cache_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [10:0] address, [18:11] write_data, rest zero
    input  wire  [salc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire  [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [7:0] read_data, [39:8] hit_total, [71:40] miss_total
    output logic [salc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] hit
    output logic [0:0]                        m_axis_tuser
);
    import salc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    salc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_mode   (s_axis_tuser[0]),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_hit   (m_axis_tuser[0]),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### bench/tb_set_associative_lru_cache_unit.sv
`timescale 1ns / 1ps
// Testbench for set_associative_lru_cache_unit: sends read and write items,
// predicts every result with a local model of the cache, and checks the output stream.
// Depends on salc_pkg and the cache RTL.
module tb_set_associative_lru_cache_unit;
    import salc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 1180;
    localparam int PRESS_ITEMS  = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    typedef enum bit {ACC_READ = 1'b0, ACC_WRITE = 1'b1} t_access;

    typedef struct {
        bit              hit;
        bit [BYTE_W-1:0] read_data;
        bit [CNT_W-1:0]  hit_total;
        bit [CNT_W-1:0]  miss_total;
    } t_lookup_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [10:0] address, [18:11] write_data
    logic [0:0]            s_axis_tuser  = '0;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [7:0] read_data, [39:8] hits, [71:40] misses
    logic [0:0]            m_axis_tuser;         // [0] hit

    // local cache model
    bit                line_ok   [SETS][WAYS];
    bit [TAG_W-1:0]    line_tagv [SETS][WAYS];
    bit [RANK_W-1:0]   way_age   [SETS][WAYS];
    bit [BYTE_W-1:0]   line_data [SETS][WAYS][LINE_BYTES];
    bit [BYTE_W-1:0]   mem_image [MEM_DEPTH];
    bit [CNT_W-1:0]    read_hits;
    bit [CNT_W-1:0]    read_misses;

    t_lookup_result    pending_results[$];
    int                mismatches    = 0;
    int                items_sent    = 0;
    int                writes_sent   = 0;
    int                hold_requests = 0;
    int                burst_left    = 0;
    bit                idle_gaps     = 1'b1;
    bit [TAG_W-1:0]    tag_base      = '0;
    int                cycle_count   = 0;

    set_associative_lru_cache_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb: timed out after %0d cycles, %0d results outstanding",
                         cycle_count, pending_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- model

    // way becomes most recent; younger-or-equal ways age by one, saturating
    function automatic void make_most_recent(int s, int w);
        int r, v;
        r = int'(way_age[s][w]);
        for (v = 0; v < WAYS; v++) begin
            if (v != w && int'(way_age[s][v]) <= r && int'(way_age[s][v]) < WAYS - 1) begin
                way_age[s][v] = way_age[s][v] + 1'b1;
            end
        end
        way_age[s][w] = '0;
    endfunction

    function automatic void refill_line(int s, bit [TAG_W-1:0] tag);
        int w, v;
        w = -1;
        for (v = 0; v < WAYS; v++) begin
            if (!line_ok[s][v] && w < 0) begin
                w = v;
            end
        end
        if (w < 0) begin
            // oldest way wins, lowest index on a tie
            w = 0;
            for (v = 1; v < WAYS; v++) begin
                if (way_age[s][v] > way_age[s][w]) begin
                    w = v;
                end
            end
        end
        line_ok[s][w]   = 1'b1;
        line_tagv[s][w] = tag;
        make_most_recent(s, w);
        for (v = 0; v < LINE_BYTES; v++) begin
            line_data[s][w][v] = mem_image[(int'(tag) << (SET_W + OFF_W)) | (s << OFF_W) | v];
        end
    endfunction

    function automatic t_lookup_result predict_access(t_access mode, bit [ADDR_W-1:0] addr,
                                                      bit [BYTE_W-1:0] wdata);
        t_lookup_result res;
        bit [TAG_W-1:0] tag;
        int s, off, v;
        tag = addr[ADDR_W-1 -: TAG_W];
        s   = int'(addr[OFF_W +: SET_W]);
        off = int'(addr[OFF_W-1:0]);
        res.hit       = 1'b0;
        res.read_data = '0;
        if (mode == ACC_READ) begin
            for (v = 0; v < WAYS; v++) begin
                if (!res.hit && line_ok[s][v] && line_tagv[s][v] == tag) begin
                    res.hit       = 1'b1;
                    res.read_data = line_data[s][v][off];
                    make_most_recent(s, v);
                end
            end
            if (res.hit) begin
                if (read_hits != '1) read_hits++;
            end else begin
                if (read_misses != '1) read_misses++;
                refill_line(s, tag);
            end
        end else begin
            // tag match drops the way whether or not it was valid
            for (v = 0; v < WAYS; v++) begin
                if (line_tagv[s][v] == tag) begin
                    line_ok[s][v] = 1'b0;
                end
            end
            mem_image[addr] = wdata;
            refill_line(s, tag);
        end
        res.hit_total  = read_hits;
        res.miss_total = read_misses;
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(t_access mode, bit [ADDR_W-1:0] addr, bit [BYTE_W-1:0] wdata);
        int gap;
        if (burst_left == 0) begin
            gap = (idle_gaps && $urandom_range(0, 2) != 0) ? $urandom_range(1, 20) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({wdata, addr});
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_access(mode, addr, wdata));
        items_sent++;
        if (mode == ACC_WRITE) writes_sent++;
    endtask

    // receiver: changing stall styles, plus a long hold-off on request
    initial begin : receiver
        int style, left, hold_seen;
        style     = 0;
        left      = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(16, 96);
                end
                left--;
                case (style)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_axis_tready <= (left % 5 != 0);
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic check_field(string name, bit [CNT_W-1:0] want, bit [CNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("tb: %s mismatch at item %0d: expected 0x%0h, got 0x%0h",
                         name, items_sent - pending_results.size(), want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("tb: unexpected result, tdata 0x%0h tuser %0b",
                             m_axis_tdata, m_axis_tuser);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("hit", CNT_W'(want.hit), CNT_W'(m_axis_tuser[0]));
                check_field("read_data", CNT_W'(want.read_data), CNT_W'(m_axis_tdata[7:0]));
                check_field("hit_total", want.hit_total, m_axis_tdata[39:8]);
                check_field("miss_total", want.miss_total, m_axis_tdata[71:40]);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    function automatic bit [ADDR_W-1:0] compose_address(int tag, int s, int off);
        return ADDR_W'((tag << (SET_W + OFF_W)) | (s << OFF_W) | off);
    endfunction

    // mostly a small rotating pool of tags so sets overflow and hits recur
    function automatic bit [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 4) == 0) begin
            return ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
        end
        return compose_address((tag_base + $urandom_range(0, WAYS + 1)) % (1 << TAG_W),
                               $urandom_range(0, SETS - 1), $urandom_range(0, LINE_BYTES - 1));
    endfunction

    function automatic bit [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_address_extremes();
        send_item(ACC_READ,  compose_address(0, 0, 0), 8'h00);   // cold miss
        send_item(ACC_READ,  compose_address(0, 0, 0), 8'hff);   // hit on cleared memory
        send_item(ACC_READ,  11'h7ff, 8'h00);
        send_item(ACC_WRITE, 11'h7ff, 8'hff);
        send_item(ACC_READ,  11'h7ff, 8'h00);
        send_item(ACC_WRITE, 11'h000, 8'ha5);
        send_item(ACC_READ,  11'h000, 8'h00);
        send_item(ACC_WRITE, 11'h000, 8'h00);
    endtask

    task automatic test_lru_replacement();
        int t;
        for (t = 1; t <= WAYS; t++) begin
            send_item(ACC_READ, compose_address(t, 5, t), 8'h00);
        end
        send_item(ACC_READ, compose_address(1, 5, 0), 8'h00);   // refresh tag 1
        send_item(ACC_READ, compose_address(5, 5, 0), 8'h00);   // evicts the oldest
        send_item(ACC_READ, compose_address(2, 5, 7), 8'h00);
        send_item(ACC_READ, compose_address(1, 5, 3), 8'h00);
    endtask

    task automatic test_write_invalidate();
        send_item(ACC_WRITE, compose_address(1, 5, 3), 8'h3c);   // resident line
        send_item(ACC_READ,  compose_address(1, 5, 3), 8'h00);
        send_item(ACC_WRITE, compose_address(9, 5, 6), 8'h81);   // absent line
        send_item(ACC_READ,  compose_address(9, 5, 6), 8'h00);
    endtask

    task automatic test_output_hold_off();
        int n;
        idle_gaps = 1'b0;
        hold_requests++;
        for (n = 0; n < PRESS_ITEMS; n++) begin
            send_item(($urandom_range(0, 3) == 0) ? ACC_WRITE : ACC_READ,
                      pick_address(), pick_byte());
        end
        idle_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(int count);
        int n;
        t_access mode;
        bit [ADDR_W-1:0] addr;
        bit [ADDR_W-1:0] last_write;
        bit follow_up;
        follow_up  = 1'b0;
        last_write = '0;
        for (n = 0; n < count; n++) begin
            if (n % 200 == 0) tag_base = TAG_W'($urandom_range(0, 31));
            if (follow_up) begin
                // read back what was just written
                send_item(ACC_READ, last_write, pick_byte());
                follow_up = 1'b0;
            end else begin
                mode = ($urandom_range(0, 3) == 0) ? ACC_WRITE : ACC_READ;
                addr = pick_address();
                send_item(mode, addr, pick_byte());
                if (mode == ACC_WRITE && $urandom_range(0, 2) == 0) begin
                    follow_up  = 1'b1;
                    last_write = addr;
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_address_extremes();
        test_lru_replacement();
        test_write_invalidate();
        test_output_hold_off();
        test_random_traffic(RANDOM_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d items checked (%0d reads, %0d writes), %0d read hits, %0d misses",
                 items_sent, items_sent - writes_sent, writes_sent, read_hits, read_misses);
        $display("tb: covered LRU eviction, write invalidate and refill, long output hold-off");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
